@@ rtl/bal_pkg.sv @@
// ----------------------------------------------------------------------------
// bal_pkg
// Shared types and constants for the bounded array list block.
// ----------------------------------------------------------------------------
package bal_pkg;

  // Default sizing
  localparam int CAPACITY_DEF   = 16;
  localparam int DATA_WIDTH_DEF = 32;

  // Fixed field widths
  localparam int CMD_W  = 3;
  localparam int POS_W  = 4;
  localparam int WORD_W = 32;
  localparam int CNT_W  = 5;
  localparam int STAT_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_RM_TAIL = 3'd2,
    CMD_RM_HEAD = 3'd3,
    CMD_READ = 3'd4,
    CMD_WRITE = 3'd5
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK = 2'd0,
    STAT_FULL = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_BADPOS = 2'd3
  } stat_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_HOLD = 1'b1
  } ctl_state_t;

endpackage

@@ rtl/bal_ctrl.sv @@
// ----------------------------------------------------------------------------
// bal_ctrl
// Handshake controller: tracks whether a result is held and issues the
// execute strobe to the datapath.
// ----------------------------------------------------------------------------
module bal_ctrl (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output logic exec
);
  import bal_pkg::*;

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_HOLD;
      end
      S_HOLD: begin
        if (out_ready && !in_valid) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
      end
      S_HOLD: begin
        out_valid = 1'b1;
        in_ready  = out_ready;  // result leaves as the next command enters
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign exec = in_valid && in_ready;

  a_exec_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    exec |=> out_valid)
    else $error("executed command did not produce a result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !exec)
    else $error("held result overwritten by new command");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input not ready with no result held");

endmodule

@@ rtl/bal_dp.sv @@
// ----------------------------------------------------------------------------
// bal_dp
// Datapath: entry register array with parallel shift, fill count, read mux
// and result registers.
// ----------------------------------------------------------------------------
module bal_dp #(
  parameter int CAPACITY   = bal_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = bal_pkg::DATA_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       exec,
  input  logic [bal_pkg::CMD_W-1:0]  cmd,
  input  logic [bal_pkg::POS_W-1:0]  position,
  input  logic [bal_pkg::WORD_W-1:0] data_in,
  output logic [bal_pkg::WORD_W-1:0] read_data,
  output logic [bal_pkg::CNT_W-1:0]  count,
  output logic [bal_pkg::STAT_W-1:0] status
);
  import bal_pkg::*;

  localparam int FILL_W   = $clog2(CAPACITY + 1);
  localparam int CMP_W    = FILL_W + POS_W;
  localparam int RD_TAPS  = (CAPACITY < (1 << POS_W)) ? CAPACITY : (1 << POS_W);
  localparam int RD_IDX_W = $clog2(RD_TAPS);

  logic [DATA_WIDTH-1:0] entries_r   [CAPACITY];
  logic [DATA_WIDTH-1:0] entries_nxt [CAPACITY];
  logic [DATA_WIDTH-1:0] rd_taps     [RD_TAPS];
  logic [FILL_W-1:0]     fill_r, fill_nxt;
  logic [WORD_W-1:0]     rd_r, rd_nxt;
  stat_t                 stat_r, stat_nxt;

  logic [CMP_W-1:0]      pos_x, fill_x;
  logic [63:0]           din_x, rd_x;
  logic [DATA_WIDTH-1:0] val;
  logic                  is_full, is_empty, pos_lt, pos_le;
  logic                  do_app, do_ins, do_rmt, do_rmh, do_rd, do_wr;

  assign pos_x   = CMP_W'(position);
  assign fill_x  = CMP_W'(fill_r);
  assign din_x   = 64'(data_in);
  assign val     = din_x[DATA_WIDTH-1:0];
  assign is_full = (fill_r == FILL_W'(CAPACITY));
  assign is_empty = (fill_r == '0);
  assign pos_lt  = (pos_x < fill_x);
  assign pos_le  = (pos_x <= fill_x);

  assign do_app = exec && (cmd == CMD_APPEND) && !is_full;
  assign do_ins = exec && (cmd == CMD_INSERT) && !is_full && pos_le;
  assign do_rmt = exec && (cmd == CMD_RM_TAIL) && !is_empty;
  assign do_rmh = exec && (cmd == CMD_RM_HEAD) && !is_empty;
  assign do_rd  = exec && (cmd == CMD_READ) && pos_lt;
  assign do_wr  = exec && (cmd == CMD_WRITE) && pos_lt;

  // status and count
  always_comb begin
    stat_nxt = STAT_OK;
    case (cmd)
      CMD_APPEND:  if (is_full) stat_nxt = STAT_FULL;
      CMD_INSERT: begin
        if (is_full) stat_nxt = STAT_FULL;
        else if (!pos_le) stat_nxt = STAT_BADPOS;
      end
      CMD_RM_TAIL, CMD_RM_HEAD: if (is_empty) stat_nxt = STAT_EMPTY;
      CMD_READ, CMD_WRITE:      if (!pos_lt) stat_nxt = STAT_BADPOS;
      default: stat_nxt = STAT_OK;
    endcase
  end

  always_comb begin
    fill_nxt = fill_r;
    if (do_app || do_ins) fill_nxt = fill_r + FILL_W'(1);
    else if (do_rmt || do_rmh) fill_nxt = fill_r - FILL_W'(1);
  end

  // per-entry next value; shifts use fixed neighbors only
  for (genvar k = 0; k < CAPACITY; k++) begin : g_entry
    logic [DATA_WIDTH-1:0] prev_w, next_w;
    logic [CMP_W-1:0]      k_x;

    assign k_x = CMP_W'(k);

    if (k > 0) begin : g_prev
      assign prev_w = entries_r[k-1];
    end else begin : g_prev0
      assign prev_w = entries_r[k];
    end

    if (k < CAPACITY - 1) begin : g_next
      assign next_w = entries_r[k+1];
    end else begin : g_nextl
      assign next_w = entries_r[k];
    end

    always_comb begin
      entries_nxt[k] = entries_r[k];
      if (do_app && (fill_r == FILL_W'(k))) entries_nxt[k] = val;
      else if (do_ins && (k_x == pos_x)) entries_nxt[k] = val;
      else if (do_ins && (k_x > pos_x)) entries_nxt[k] = prev_w;
      else if (do_rmh) entries_nxt[k] = next_w;
      else if (do_wr && (k_x == pos_x)) entries_nxt[k] = val;
    end

    always_ff @(posedge clk) begin
      entries_r[k] <= entries_nxt[k];
    end
  end

  // read reaches only the entries the position field can name
  for (genvar j = 0; j < RD_TAPS; j++) begin : g_tap
    assign rd_taps[j] = entries_r[j];
  end

  assign rd_x   = 64'(rd_taps[position[RD_IDX_W-1:0]]);
  assign rd_nxt = do_rd ? rd_x[WORD_W-1:0] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      rd_r   <= rd_nxt;
      stat_r <= stat_nxt;
    end
  end

  logic [CMP_W-1:0] cnt_x;
  assign cnt_x     = CMP_W'(fill_r);
  assign count     = cnt_x[CNT_W-1:0];
  assign read_data = rd_r;
  assign status    = stat_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(CAPACITY))
    else $error("fill count above capacity");

  a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (do_app || do_ins) |=> (fill_r == $past(fill_r) + FILL_W'(1)))
    else $error("successful add did not grow the list");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (exec && is_full && (cmd == CMD_APPEND)) |=> (stat_r == STAT_FULL && $stable(fill_r)))
    else $error("append on full list not reported");

endmodule

@@ rtl/bounded_array_list.sv @@
// ----------------------------------------------------------------------------
// bounded_array_list
// Fixed-capacity ordered list in a register array: append, insert, remove
// tail, remove head, read and write, one result per command.
// ----------------------------------------------------------------------------
//
//   channel  ports                                   direction
//   -------  --------------------------------------  ---------
//   in       in_valid/in_ready, cmd, position, data   into block
//   out      out_valid/out_ready, read_data, count,   out of block
//            status
//
// One command per cycle while out_ready is high: a command executes in the
// cycle of its transfer; its result appears in the output register next cycle.
// A new command is taken in the same cycle the held result transfers out, so
// a stall on the result side stalls the input by exactly that long.
// Insert shifts above position, remove head all, at once via neighbor muxes.
// Reset clears the fill count and output valid; entry contents are kept.
// ----------------------------------------------------------------------------
module bounded_array_list #(
  parameter int CAPACITY   = bal_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = bal_pkg::DATA_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [bal_pkg::CMD_W-1:0]  in_cmd,
  input  logic [bal_pkg::POS_W-1:0]  in_position,
  input  logic [bal_pkg::WORD_W-1:0] in_data_in,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [bal_pkg::WORD_W-1:0] out_read_data,
  output logic [bal_pkg::CNT_W-1:0]  out_count,
  output logic [bal_pkg::STAT_W-1:0] out_status
);
  import bal_pkg::*;

  // execute strobe: command transfer this cycle
  logic exec;

  bal_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .exec      (exec)
  );

  bal_dp #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .exec      (exec),
    .cmd       (in_cmd),
    .position  (in_position),
    .data_in   (in_data_in),
    .read_data (out_read_data),
    .count     (out_count),
    .status    (out_status)
  );

endmodule
